// ===== rtl/sic_pkg.sv =====
package sic_pkg;

  // functional units
  localparam int NUNITS = 5;
  localparam logic [2:0] UNIT_INT   = 3'd0;
  localparam logic [2:0] UNIT_MULT1 = 3'd1;
  localparam logic [2:0] UNIT_MULT2 = 3'd2;
  localparam logic [2:0] UNIT_ADD   = 3'd3;
  localparam logic [2:0] UNIT_DIV   = 3'd4;
  localparam logic [2:0] NO_UNIT    = 3'd7;

  // opcodes
  localparam logic [2:0] OP_LD   = 3'd0;
  localparam logic [2:0] OP_MULD = 3'd1;
  localparam logic [2:0] OP_DIVD = 3'd2;
  localparam logic [2:0] OP_SUBD = 3'd3;
  localparam logic [2:0] OP_ADDD = 3'd4;

  // latency register indexes
  localparam logic [2:0] REG_LOAD_LAT = 3'd0;
  localparam logic [2:0] REG_MUL_LAT  = 3'd1;
  localparam logic [2:0] REG_DIV_LAT  = 3'd2;
  localparam logic [2:0] REG_SUB_LAT  = 3'd3;
  localparam logic [2:0] REG_ADD_LAT  = 3'd4;
  localparam int NLAT = 5;

  localparam logic [7:0] LOAD_LAT_RST = 8'd1;
  localparam logic [7:0] MUL_LAT_RST  = 8'd10;
  localparam logic [7:0] DIV_LAT_RST  = 8'd40;
  localparam logic [7:0] SUB_LAT_RST  = 8'd2;
  localparam logic [7:0] ADD_LAT_RST  = 8'd2;

  // architectural registers r1 .. NUM_REGS, the last is the base register
  localparam logic [3:0] NUM_REGS = 4'd13;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READ  = 2'd1,
    PH_EXEC  = 2'd2,
    PH_WRITE = 2'd3
  } phase_t;

endpackage

// ===== rtl/scoreboard_issue_control.sv =====
// channel | dir | payload
// in_     | in  | tuser: instr_valid; tdata: opcode, dest_reg, src1_reg, src2_reg
// out_    | out | tuser: issued; tdata: issue_unit, read/done/write/busy masks
// cfg_    | in  | apb, latency registers at 4*i (load, mul, div, sub, add)
//
// one tick per transfer; a tick enters the input register and is evaluated from there
// into the output register, so one tick per clock is sustained while the output drains.
// the scoreboard update is a single pass of compare and select logic over five units.
// synchronous active-low reset empties both registers and idles all units.
// a stalled output holds its result; the input side keeps taking ticks as long as
// the output register is empty or being drained.
module scoreboard_issue_control
  import sic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // opcode[2:0], dest_reg[6:3], src1_reg[10:7], src2_reg[14:11]
  input  logic        in_tuser,   // instr_valid[0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // issue_unit[2:0], read_mask[7:3], done_mask[12:8],
                                  // write_mask[17:13], busy_mask[22:18]
  output logic        out_tuser,  // issued[0]
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // latency registers
  logic [7:0] lat_r [NLAT];

  // input register
  logic       in_valid_r;
  logic       instr_valid_r;
  logic [2:0] op_r;
  logic [3:0] dest_in_r;
  logic [3:0] s1_in_r;
  logic [3:0] s2_in_r;

  // unit state
  logic [NUNITS-1:0] busy_r, busy_nxt;
  logic [NUNITS-1:0] rdy1_r, rdy1_nxt;
  logic [NUNITS-1:0] rdy2_r, rdy2_nxt;
  logic [3:0]        dest_r [NUNITS];
  logic [3:0]        dest_nxt [NUNITS];
  logic [3:0]        src1_r [NUNITS];
  logic [3:0]        src1_nxt [NUNITS];
  logic [3:0]        src2_r [NUNITS];
  logic [3:0]        src2_nxt [NUNITS];
  logic [2:0]        wait1_r [NUNITS];
  logic [2:0]        wait1_nxt [NUNITS];
  logic [2:0]        wait2_r [NUNITS];
  logic [2:0]        wait2_nxt [NUNITS];
  phase_t            phase_r [NUNITS];
  phase_t            phase_nxt [NUNITS];
  logic [7:0]        cd_r [NUNITS];
  logic [7:0]        cd_nxt [NUNITS];
  logic              add_sub_r, add_sub_nxt;

  // output register
  logic        out_valid_r;
  logic        issued_r;
  logic [2:0]  iunit_r;
  logic [4:0]  read_r, done_r, write_r, bmask_r;

  // tick results
  logic              issue_c;
  logic [2:0]        iunit_c;
  logic [NUNITS-1:0] read_c, done_c, write_c;

  logic advance;
  logic cfg_wr;
  logic [2:0] cfg_idx;

  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r[REG_LOAD_LAT] <= LOAD_LAT_RST;
      lat_r[REG_MUL_LAT]  <= MUL_LAT_RST;
      lat_r[REG_DIV_LAT]  <= DIV_LAT_RST;
      lat_r[REG_SUB_LAT]  <= SUB_LAT_RST;
      lat_r[REG_ADD_LAT]  <= ADD_LAT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LOAD_LAT: lat_r[REG_LOAD_LAT] <= cfg_pwdata[7:0];
        REG_MUL_LAT:  lat_r[REG_MUL_LAT]  <= cfg_pwdata[7:0];
        REG_DIV_LAT:  lat_r[REG_DIV_LAT]  <= cfg_pwdata[7:0];
        REG_SUB_LAT:  lat_r[REG_SUB_LAT]  <= cfg_pwdata[7:0];
        REG_ADD_LAT:  lat_r[REG_ADD_LAT]  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    cfg_prdata = 32'd0;
    case (cfg_idx)
      REG_LOAD_LAT: cfg_prdata = {24'd0, lat_r[REG_LOAD_LAT]};
      REG_MUL_LAT:  cfg_prdata = {24'd0, lat_r[REG_MUL_LAT]};
      REG_DIV_LAT:  cfg_prdata = {24'd0, lat_r[REG_DIV_LAT]};
      REG_SUB_LAT:  cfg_prdata = {24'd0, lat_r[REG_SUB_LAT]};
      REG_ADD_LAT:  cfg_prdata = {24'd0, lat_r[REG_ADD_LAT]};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      instr_valid_r <= in_tuser;
      op_r          <= in_tdata[2:0];
      dest_in_r     <= in_tdata[6:3];
      s1_in_r       <= in_tdata[10:7];
      s2_in_r       <= in_tdata[14:11];
    end
  end

  // one scoreboard tick
  always_comb begin
    logic [3:0] s1, s2;
    logic [2:0] w1, w2, tgt;
    logic       tgt_ok, d_ok, waw, tgt_busy, war;
    logic [7:0] cd_dec, lat;

    busy_nxt    = busy_r;
    rdy1_nxt    = rdy1_r;
    rdy2_nxt    = rdy2_r;
    add_sub_nxt = add_sub_r;
    dest_nxt    = dest_r;
    src1_nxt    = src1_r;
    src2_nxt    = src2_r;
    wait1_nxt   = wait1_r;
    wait2_nxt   = wait2_r;
    phase_nxt   = phase_r;
    cd_nxt      = cd_r;
    read_c      = '0;
    done_c      = '0;
    write_c     = '0;
    issue_c     = 1'b0;
    iunit_c     = UNIT_INT;
    cd_dec      = 8'd0;

    // write result, held while another busy unit still has to read that register
    for (int u = 0; u < NUNITS; u++) begin
      war = 1'b0;
      for (int f = 0; f < NUNITS; f++) begin
        if (f != u && busy_r[f] &&
            ((src1_r[f] == dest_r[u] && rdy1_r[f]) ||
             (src2_r[f] == dest_r[u] && rdy2_r[f]))) begin
          war = 1'b1;
        end
      end
      write_c[u] = busy_r[u] && phase_r[u] == PH_WRITE && !war;
    end

    // execute countdown
    for (int u = 0; u < NUNITS; u++) begin
      if (busy_r[u] && phase_r[u] == PH_EXEC) begin
        cd_dec    = (cd_r[u] != 8'd0) ? cd_r[u] - 8'd1 : 8'd0;
        cd_nxt[u] = cd_dec;
        if (cd_dec == 8'd0) begin
          phase_nxt[u] = PH_WRITE;
          done_c[u]    = 1'b1;
        end
      end
    end

    // read operands
    for (int u = 0; u < NUNITS; u++) begin
      case (3'(u))
        UNIT_INT:   lat = lat_r[REG_LOAD_LAT];
        UNIT_MULT1: lat = lat_r[REG_MUL_LAT];
        UNIT_MULT2: lat = lat_r[REG_MUL_LAT];
        UNIT_ADD:   lat = add_sub_r ? lat_r[REG_SUB_LAT] : lat_r[REG_ADD_LAT];
        UNIT_DIV:   lat = lat_r[REG_DIV_LAT];
        default:    lat = 8'd1;
      endcase
      if (lat == 8'd0) lat = 8'd1;
      if (busy_r[u] && phase_r[u] == PH_READ &&
          wait1_r[u] == NO_UNIT && wait2_r[u] == NO_UNIT) begin
        phase_nxt[u] = PH_EXEC;
        rdy1_nxt[u]  = 1'b0;
        rdy2_nxt[u]  = 1'b0;
        cd_nxt[u]    = lat;
        read_c[u]    = 1'b1;
      end
    end

    // issue: target unit, source and destination lookups over the busy units
    tgt_ok = 1'b1;
    case (op_r)
      OP_LD:   tgt = UNIT_INT;
      OP_MULD: tgt = busy_r[UNIT_MULT1] ? UNIT_MULT2 : UNIT_MULT1;
      OP_DIVD: tgt = UNIT_DIV;
      OP_SUBD: tgt = UNIT_ADD;
      OP_ADDD: tgt = UNIT_ADD;
      default: begin
        tgt    = UNIT_INT;
        tgt_ok = 1'b0;
      end
    endcase
    d_ok = dest_in_r != 4'd0 && dest_in_r <= NUM_REGS;
    s1   = (s1_in_r <= NUM_REGS) ? s1_in_r : 4'd0;
    s2   = (s2_in_r <= NUM_REGS) ? s2_in_r : 4'd0;
    w1   = NO_UNIT;
    w2   = NO_UNIT;
    waw  = 1'b0;
    tgt_busy = 1'b0;
    for (int u = 0; u < NUNITS; u++) begin
      if (busy_r[u] && s1 != 4'd0 && dest_r[u] == s1) w1 = 3'(u);
      if (busy_r[u] && s2 != 4'd0 && dest_r[u] == s2) w2 = 3'(u);
      if (busy_r[u] && dest_r[u] == dest_in_r) waw = 1'b1;
      if (busy_r[u] && tgt == 3'(u)) tgt_busy = 1'b1;
    end
    issue_c = instr_valid_r && tgt_ok && d_ok && !tgt_busy && !waw;
    if (issue_c) iunit_c = tgt;
    for (int u = 0; u < NUNITS; u++) begin
      if (issue_c && tgt == 3'(u)) begin
        busy_nxt[u]  = 1'b1;
        dest_nxt[u]  = dest_in_r;
        src1_nxt[u]  = s1;
        src2_nxt[u]  = s2;
        wait1_nxt[u] = w1;
        wait2_nxt[u] = w2;
        rdy1_nxt[u]  = s1 != 4'd0 && w1 == NO_UNIT;
        rdy2_nxt[u]  = s2 != 4'd0 && w2 == NO_UNIT;
        phase_nxt[u] = PH_READ;
        cd_nxt[u]    = 8'd0;
      end
    end
    if (issue_c && tgt == UNIT_ADD) add_sub_nxt = op_r == OP_SUBD;

    // free units that wrote
    for (int u = 0; u < NUNITS; u++) begin
      if (write_c[u]) begin
        busy_nxt[u]  = 1'b0;
        dest_nxt[u]  = 4'd0;
        src1_nxt[u]  = 4'd0;
        src2_nxt[u]  = 4'd0;
        wait1_nxt[u] = NO_UNIT;
        wait2_nxt[u] = NO_UNIT;
        rdy1_nxt[u]  = 1'b0;
        rdy2_nxt[u]  = 1'b0;
        phase_nxt[u] = PH_IDLE;
        cd_nxt[u]    = 8'd0;
      end
    end

    // release waiters of the units that wrote
    for (int f = 0; f < NUNITS; f++) begin
      for (int u = 0; u < NUNITS; u++) begin
        if (write_c[u] && wait1_nxt[f] == 3'(u)) begin
          wait1_nxt[f] = NO_UNIT;
          rdy1_nxt[f]  = 1'b1;
        end
        if (write_c[u] && wait2_nxt[f] == 3'(u)) begin
          wait2_nxt[f] = NO_UNIT;
          rdy2_nxt[f]  = 1'b1;
        end
      end
    end
  end

  // unit state update, once per evaluated tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= '0;
      rdy1_r    <= '0;
      rdy2_r    <= '0;
      add_sub_r <= 1'b0;
      for (int u = 0; u < NUNITS; u++) begin
        dest_r[u]  <= 4'd0;
        src1_r[u]  <= 4'd0;
        src2_r[u]  <= 4'd0;
        wait1_r[u] <= NO_UNIT;
        wait2_r[u] <= NO_UNIT;
        phase_r[u] <= PH_IDLE;
        cd_r[u]    <= 8'd0;
      end
    end else if (advance) begin
      busy_r    <= busy_nxt;
      rdy1_r    <= rdy1_nxt;
      rdy2_r    <= rdy2_nxt;
      add_sub_r <= add_sub_nxt;
      dest_r    <= dest_nxt;
      src1_r    <= src1_nxt;
      src2_r    <= src2_nxt;
      wait1_r   <= wait1_nxt;
      wait2_r   <= wait2_nxt;
      phase_r   <= phase_nxt;
      cd_r      <= cd_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      issued_r <= issue_c;
      iunit_r  <= iunit_c;
      read_r   <= read_c;
      done_r   <= done_c;
      write_r  <= write_c;
      bmask_r  <= busy_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = issued_r;
  assign out_tdata  = {1'b0, bmask_r, write_r, done_r, read_r, iunit_r};

  // checks
  logic dest_clash;
  logic wait_late;
  logic issue_not_busy;

  always_comb begin
    dest_clash = 1'b0;
    wait_late  = 1'b0;
    for (int u = 0; u < NUNITS; u++) begin
      for (int f = u + 1; f < NUNITS; f++) begin
        if (busy_r[u] && busy_r[f] && dest_r[u] == dest_r[f]) dest_clash = 1'b1;
      end
      if (busy_r[u] && (phase_r[u] == PH_EXEC || phase_r[u] == PH_WRITE) &&
          (wait1_r[u] != NO_UNIT || wait2_r[u] != NO_UNIT)) wait_late = 1'b1;
    end
    issue_not_busy = 1'b0;
    for (int u = 0; u < NUNITS; u++) begin
      if (issued_r && iunit_r == 3'(u) && !bmask_r[u]) issue_not_busy = 1'b1;
    end
  end

  a_unique_dest: assert property (@(posedge clk) disable iff (!rst_n) !dest_clash)
    else $error("two busy units share a destination");
  a_no_wait_after_read: assert property (@(posedge clk) disable iff (!rst_n) !wait_late)
    else $error("unit past operand read still waits on a writer");
  a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !issue_not_busy)
    else $error("issued unit not shown busy");
  a_read_write_apart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (read_r & write_r) == 5'd0)
    else $error("unit read and wrote in the same tick");
  a_take_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

endmodule
